// ===== rtl/pat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pat_pkg;

  // table geometry
  localparam int PAT_ENTRIES = 16;
  localparam int PAT_IDX_W   = (PAT_ENTRIES > 1) ? $clog2(PAT_ENTRIES) : 1;
  localparam int PAT_CNT_W   = $clog2(PAT_ENTRIES + 1);

  // result field widths
  localparam int PAT_POS_W = 4;
  localparam int PAT_OCC_W = 5;

  // request modes
  localparam logic PAT_MODE_ADD    = 1'b0;
  localparam logic PAT_MODE_REMOVE = 1'b1;

  // request beat
  typedef struct packed {
    logic        mode;
    logic [31:0] origin_id;
    logic [31:0] seq_num;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [31:0] now_time;
  } pat_in_t;

  // result beat
  typedef struct packed {
    logic                 found;
    logic [PAT_POS_W-1:0] position;
    logic                 dropped;
    logic [PAT_OCC_W-1:0] occupancy;
  } pat_out_t;

  // one stored entry
  typedef struct packed {
    logic [31:0] sender;
    logic [31:0] seq;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] sent_time;
  } pat_entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic capture;   // latch match against the incoming request
    logic update;    // apply the table change
    logic remove;    // request is a remove
    logic found;     // some cell matched
  } pat_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/pat_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pat_cell
  import pat_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire pat_cmd_t   cmd,
  input  wire pat_in_t    probe,        // request being accepted, for the compare
  input  wire pat_in_t    req,          // registered request, for loading
  input  wire logic       append_here,  // this cell is the tail slot of an append
  input  wire logic       hit_in,       // an older cell matched
  input  wire pat_entry_t next_entry,   // younger neighbor contents
  input  wire logic       next_valid,
  output logic            hit_out,
  output logic            first,
  output pat_entry_t      entry,
  output logic            valid
);

  logic       valid_r;
  logic       match_r;
  pat_entry_t entry_r;
  logic       eq;
  logic       load;
  logic       shift;

  // entry compare against the incoming request
  assign eq = (entry_r.sender == probe.origin_id) && (probe.seq_num >= entry_r.seq) &&
              (entry_r.ip == probe.peer_ip) && (entry_r.port == probe.peer_port);

  // oldest-match chain
  assign hit_out = hit_in | match_r;
  assign first   = match_r & ~hit_in;

  // refresh in place or append at tail; remove shifts from the match onward
  assign load  = ~cmd.remove & (first | append_here);
  assign shift = cmd.remove & cmd.found & hit_out;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        match_r <= valid_r & eq;
      end
      if (cmd.update) begin
        if (load) begin
          valid_r <= 1'b1;
        end else if (shift) begin
          valid_r <= next_valid;
        end
      end
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (cmd.update && load) begin
      entry_r.sender    <= req.origin_id;
      entry_r.seq       <= req.seq_num;
      entry_r.ip        <= req.peer_ip;
      entry_r.port      <= req.peer_port;
      entry_r.sent_time <= req.now_time;
    end else if (cmd.update && shift) begin
      entry_r <= next_entry;
    end
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule
`default_nettype wire

// ===== rtl/pending_ack_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   | ports                  | beat moves when
// ----------+------------------------+------------------------------
// request   | start, busy, in_data   | start high and busy low
// result    | out_valid, out_data    | out_valid high (one cycle)
//
// for each request the accept edge registers the compare of every cell,
// the next edge applies the refresh, append or compacting shift and
// registers the result; busy is high for the one cycle in between.
// the match priority ripples through the row of cells within that cycle.
// rst_n (synchronous) empties the table; no clearing pass is needed.
// the receiver cannot stall: each result is shown for exactly one cycle.
module pending_ack_table
  import pat_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire pat_in_t in_data,
  output logic         out_valid,
  output pat_out_t     out_data
);

  logic                 busy_r;
  logic                 out_valid_r;
  pat_out_t             out_data_r;
  pat_out_t             out_data_nxt;
  pat_in_t              req_r;
  logic [PAT_CNT_W-1:0] occ_r;
  logic [PAT_CNT_W-1:0] occ_nxt;
  logic                 accept;
  logic                 full;
  logic                 append;
  logic                 dropped;
  logic [PAT_IDX_W-1:0] pos;
  pat_cmd_t             cmd;

  logic       hit   [0:PAT_ENTRIES];
  pat_entry_t ent   [0:PAT_ENTRIES];
  logic       vld   [0:PAT_ENTRIES];
  logic       first [0:PAT_ENTRIES-1];
  logic       app   [0:PAT_ENTRIES-1];

  assign accept = start & ~busy_r;
  assign full   = (occ_r == PAT_CNT_W'(PAT_ENTRIES));

  // broadcast command
  assign cmd.capture = accept;
  assign cmd.update  = busy_r;
  assign cmd.remove  = (req_r.mode == PAT_MODE_REMOVE);
  assign cmd.found   = hit[PAT_ENTRIES];

  assign append  = (req_r.mode == PAT_MODE_ADD) & ~cmd.found & ~full;
  assign dropped = (req_r.mode == PAT_MODE_ADD) & ~cmd.found & full;

  // chain ends
  assign hit[0]           = 1'b0;
  assign ent[PAT_ENTRIES] = '0;
  assign vld[PAT_ENTRIES] = 1'b0;

  // row of cells
  for (genvar i = 0; i < PAT_ENTRIES; i++) begin : g_cell
    assign app[i] = append & (occ_r == PAT_CNT_W'(i));

    pat_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .probe      (in_data),
      .req        (req_r),
      .append_here(app[i]),
      .hit_in     (hit[i]),
      .next_entry (ent[i+1]),
      .next_valid (vld[i+1]),
      .hit_out    (hit[i+1]),
      .first      (first[i]),
      .entry      (ent[i]),
      .valid      (vld[i])
    );
  end

  // position of the matched or appended entry
  always_comb begin
    pos = '0;
    for (int i = 0; i < PAT_ENTRIES; i++) begin
      if (first[i]) begin
        pos = pos | PAT_IDX_W'(i);
      end
    end
    if (append) begin
      pos = occ_r[PAT_IDX_W-1:0];
    end
  end

  // occupancy after the request
  always_comb begin
    occ_nxt = occ_r;
    if (append) begin
      occ_nxt = occ_r + PAT_CNT_W'(1);
    end else if (cmd.remove && cmd.found) begin
      occ_nxt = occ_r - PAT_CNT_W'(1);
    end
  end

  // result beat
  always_comb begin
    out_data_nxt.found     = cmd.found;
    out_data_nxt.position  = PAT_POS_W'(pos);
    out_data_nxt.dropped   = dropped;
    out_data_nxt.occupancy = PAT_OCC_W'(occ_nxt);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      occ_r       <= '0;
    end else begin
      busy_r      <= accept;
      out_valid_r <= busy_r;
      if (busy_r) begin
        occ_r <= occ_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (busy_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
